@@ sv/tlbpft_pkg.sv @@
// ----------------------------------------------------------------------------
// TLB page frame translator package
// Sizes, field widths, controller state type, command/status structs and
// small helper functions shared by the controller and the datapath.
// ----------------------------------------------------------------------------
package tlbpft_pkg;

  // Geometry
  localparam int NUM_FRAMES  = 16;
  localparam int TLB_ENTRIES = 16;
  localparam int PAGE_BYTES  = 256;

  localparam int FRAME_W   = $clog2(NUM_FRAMES);
  localparam int TLB_W     = $clog2(TLB_ENTRIES);
  localparam int OFF_W     = $clog2(PAGE_BYTES);
  localparam int PA_FULL_W = FRAME_W + OFF_W;

  // Fixed field widths
  localparam int PAGE_W     = 8;
  localparam int OFFSET_W   = 8;
  localparam int PADDR_W    = 12;
  localparam int FIDX_W     = 4;
  localparam int CNT_W      = 32;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 80;
  localparam int OUT_USER_W = 3;

  localparam logic [CNT_W-1:0]    CNT_MAX  = '1;
  localparam logic [OFFSET_W-1:0] OFF_MASK = OFFSET_W'(PAGE_BYTES - 1);

  typedef logic [FRAME_W-1:0] frame_t;
  typedef logic [TLB_W-1:0]   slot_t;
  typedef logic [PAGE_W-1:0]  page_t;
  typedef logic [CNT_W-1:0]   cnt_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_SCAN,
    ST_FINISH
  } ctrl_state_e;

  // Controller -> datapath
  typedef struct packed {
    logic accept;   // latch the incoming request
    logic lookup;   // search TLB and frame tags, update hit/miss counters
    logic scan;     // one step of the fewest-loads victim search
    logic finish;   // commit the fault and load the result register
  } dp_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic tlb_hit;
    logic resident;
    logic free_avail;
    logic scan_last;
    logic out_busy;
  } dp_status_t;

  function automatic cnt_t sat_inc(input cnt_t v);
    sat_inc = (v == CNT_MAX) ? v : v + cnt_t'(1);
  endfunction

  function automatic logic [PADDR_W-1:0] phys_addr_f(input frame_t f,
                                                     input logic [OFFSET_W-1:0] off);
    logic [PA_FULL_W-1:0] full;
    full = PA_FULL_W'(f) << OFF_W;
    full = full | PA_FULL_W'(off & OFF_MASK);
    phys_addr_f = PADDR_W'(full);
  endfunction

endpackage

@@ sv/tlbpft_ctrl.sv @@
// ----------------------------------------------------------------------------
// TLB page frame translator controller
// Sequences one request through lookup, optional victim scan and commit.
// ----------------------------------------------------------------------------
module tlbpft_ctrl
  import tlbpft_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_tvalid_i,
  output logic       s_tready_o,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_tvalid_i) state_d = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        if (!status_i.tlb_hit && !status_i.resident && !status_i.free_avail) begin
          state_d = ST_SCAN;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_SCAN: begin
        if (status_i.scan_last) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (!status_i.out_busy) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      ST_IDLE: begin
        s_tready_o   = 1'b1;
        cmd_o.accept = s_tvalid_i;
      end
      ST_LOOKUP: cmd_o.lookup = 1'b1;
      ST_SCAN:   cmd_o.scan   = 1'b1;
      ST_FINISH: cmd_o.finish = !status_i.out_busy;
      default: ;
    endcase
  end

endmodule

@@ sv/tlbpft_dp.sv @@
// ----------------------------------------------------------------------------
// TLB page frame translator datapath
// TLB and frame tables, counters, victim search and the result register.
// ----------------------------------------------------------------------------
module tlbpft_dp
  import tlbpft_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  dp_cmd_t               cmd_i,
  output dp_status_t            status_o,
  input  logic [IN_DATA_W-1:0]  s_tdata_i,
  output logic                  m_tvalid_o,
  input  logic                  m_tready_i,
  output logic [OUT_DATA_W-1:0] m_tdata_o,
  output logic [OUT_USER_W-1:0] m_tuser_o
);

  // Request
  page_t                page_q;
  logic [OFFSET_W-1:0]  offset_q;

  // Tables
  logic   [TLB_ENTRIES-1:0] tlb_valid_q;
  page_t                    tlb_page_q  [TLB_ENTRIES];
  frame_t                   tlb_frame_q [TLB_ENTRIES];
  logic   [NUM_FRAMES-1:0]  occ_q;
  page_t                    frame_page_q [NUM_FRAMES];
  cnt_t                     loads_q      [NUM_FRAMES];

  // Counters and per-request decision
  cnt_t   hits_q, misses_q;
  slot_t  slot_q;
  logic   hit_q, fault_q, evict_q;
  frame_t frame_q;
  frame_t scan_q;
  cnt_t   best_cnt_q;

  // Result register
  logic                  out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q;
  logic [OUT_USER_W-1:0] out_user_q;

  // Lookup logic
  logic   tlb_hit_c, resident_c, free_c;
  frame_t tlb_frame_c, res_frame_c, free_frame_c;

  always_comb begin
    tlb_hit_c   = 1'b0;
    tlb_frame_c = '0;
    for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
      if (tlb_valid_q[i] && tlb_page_q[i] == page_q) begin
        tlb_hit_c   = 1'b1;
        tlb_frame_c = tlb_frame_q[i];
      end
    end
  end

  always_comb begin
    resident_c   = 1'b0;
    res_frame_c  = '0;
    free_c       = 1'b0;
    free_frame_c = '0;
    for (int f = NUM_FRAMES - 1; f >= 0; f--) begin
      if (occ_q[f] && frame_page_q[f] == page_q) begin
        resident_c  = 1'b1;
        res_frame_c = frame_t'(f);
      end
      if (!occ_q[f]) begin
        free_c       = 1'b1;
        free_frame_c = frame_t'(f);
      end
    end
  end

  assign status_o.tlb_hit    = tlb_hit_c;
  assign status_o.resident   = resident_c;
  assign status_o.free_avail = free_c;
  assign status_o.scan_last  = (scan_q == frame_t'(NUM_FRAMES - 1));
  assign status_o.out_busy   = out_valid_q && !m_tready_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      page_q   <= s_tdata_i[PAGE_W-1:0];
      offset_q <= s_tdata_i[PAGE_W +: OFFSET_W];
    end
  end

  // Decision registers and victim search
  always_ff @(posedge clk_i) begin
    if (cmd_i.lookup) begin
      hit_q      <= tlb_hit_c;
      fault_q    <= !tlb_hit_c && !resident_c;
      evict_q    <= !tlb_hit_c && !resident_c && !free_c;
      best_cnt_q <= loads_q[0];
      scan_q     <= frame_t'(1);
      if (tlb_hit_c) begin
        frame_q <= tlb_frame_c;
      end else if (resident_c) begin
        frame_q <= res_frame_c;
      end else begin
        frame_q <= free_frame_c;   // zero when no frame is free
      end
    end else if (cmd_i.scan) begin
      if (loads_q[scan_q] < best_cnt_q) begin
        best_cnt_q <= loads_q[scan_q];
        frame_q    <= scan_q;
      end
      scan_q <= scan_q + frame_t'(1);
    end
  end

  // Counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hits_q   <= '0;
      misses_q <= '0;
      slot_q   <= '0;
    end else if (cmd_i.lookup) begin
      if (tlb_hit_c) begin
        hits_q <= sat_inc(hits_q);
      end else if (misses_q != CNT_MAX) begin
        misses_q <= misses_q + cnt_t'(1);
        slot_q   <= (slot_q == slot_t'(TLB_ENTRIES - 1)) ? '0 : slot_q + slot_t'(1);
      end
    end
  end

  // Table control bits and load counts
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tlb_valid_q <= '0;
      occ_q       <= '0;
      for (int f = 0; f < NUM_FRAMES; f++) loads_q[f] <= '0;
    end else if (cmd_i.finish && fault_q) begin
      occ_q[frame_q]   <= 1'b1;
      loads_q[frame_q] <= evict_q ? sat_inc(best_cnt_q) : cnt_t'(1);
      // install the new mapping, drop stale mappings of the frame elsewhere
      for (int i = 0; i < TLB_ENTRIES; i++) begin
        if (slot_t'(i) == slot_q) begin
          tlb_valid_q[i] <= 1'b1;
        end else if (tlb_valid_q[i] && tlb_frame_q[i] == frame_q) begin
          tlb_valid_q[i] <= 1'b0;
        end
      end
    end
  end

  // Table payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish && fault_q) begin
      frame_page_q[frame_q] <= page_q;
      tlb_page_q[slot_q]    <= page_q;
      tlb_frame_q[slot_q]   <= frame_q;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_data_q <= {misses_q, hits_q, FIDX_W'(frame_q), phys_addr_f(frame_q, offset_q)};
      out_user_q <= {evict_q, fault_q, hit_q};
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_data_q;
  assign m_tuser_o  = out_user_q;

endmodule

@@ sv/tlb_page_frame_translator_unit.sv @@
// ----------------------------------------------------------------------------
// TLB page frame translator
// Virtual to physical translation with a TLB and fewest-loads frame reuse.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel (s_t*) takes one request: a virtual page and a byte offset.
//   Master channel (m_t*) returns one result per request: the physical
//   address, the frame, hit/fault/evict flags and the saturating TLB hit and
//   miss totals after this request.
//   Requests are taken one at a time. s_tready_o is high only while the
//   controller is idle. A TLB hit or a resident page passes through accept,
//   lookup and commit, and the result register is loaded at the commit.
//   A fault with no free frame adds a scan of load counts, one frame per
//   cycle, between lookup and commit.
//   The result sits in an output register; if the receiver stalls, the next
//   request is still accepted and looked up, and the commit step holds until
//   the register drains.
//   Reset clears the TLB valid bits, frame occupancy, load counts and both
//   totals at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module tlb_page_frame_translator_unit
  import tlbpft_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_tvalid_i,
  output logic                  s_tready_o,
  input  logic [IN_DATA_W-1:0]  s_tdata_i,   // [7:0] virt_page, [15:8] page_offset
  output logic                  m_tvalid_o,
  input  logic                  m_tready_i,
  output logic [OUT_DATA_W-1:0] m_tdata_o,   // [11:0] phys_addr, [15:12] frame_index,
                                             // [47:16] hit_total, [79:48] miss_total
  output logic [OUT_USER_W-1:0] m_tuser_o    // [0] tlb_hit, [1] page_fault, [2] evicted
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // Sequence each request
  tlbpft_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Hold tables, counters and the result register
  tlbpft_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .s_tdata_i  (s_tdata_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tuser_o  (m_tuser_o)
  );

endmodule

@@ sv/tlbpft_checker.sv @@
// ----------------------------------------------------------------------------
// TLB page frame translator checker
// Port-level properties of the translator, bound to the top level.
// ----------------------------------------------------------------------------
module tlbpft_checker
  import tlbpft_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_tvalid_i,
  input logic                  s_tready_o,
  input logic                  m_tvalid_o,
  input logic                  m_tready_i,
  input logic [OUT_DATA_W-1:0] m_tdata_o,
  input logic [OUT_USER_W-1:0] m_tuser_o
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !m_tready_i |=> m_tvalid_o && $stable(m_tdata_o) && $stable(m_tuser_o))
    else $error("stalled result changed");

  // One request at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid_i && s_tready_o |=> !s_tready_o)
    else $error("request accepted while busy");

  // Eviction only on a fault
  a_evict_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && m_tuser_o[2] |-> m_tuser_o[1])
    else $error("eviction without page fault");

  // A TLB hit never faults and has a nonzero hit total
  a_hit_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && m_tuser_o[0] |-> !m_tuser_o[1] && (m_tdata_o[47:16] != '0))
    else $error("inconsistent hit result");

endmodule

bind tlb_page_frame_translator_unit tlbpft_checker u_tlbpft_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .s_tvalid_i (s_tvalid_i),
  .s_tready_o (s_tready_o),
  .m_tvalid_o (m_tvalid_o),
  .m_tready_i (m_tready_i),
  .m_tdata_o  (m_tdata_o),
  .m_tuser_o  (m_tuser_o)
);

@@ tb/tb_tlb_page_frame_translator_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// TLB page frame translator testbench
// Sends directed and random virtual accesses over the request stream, checks
// every result field against a cycle-free predictor of the TLB, frame table
// and fewest-loads replacement, under random gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_tlb_page_frame_translator_unit;
  import tlbpft_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int RANDOM_COUNT = 950;
  localparam int DRAIN_CYCLES = 40;
  // The worst case per request adds a sender gap, the victim scan and a
  // receiver stall, so this leaves a wide margin over roughly 1000 requests.
  localparam int LIMIT_CYCLES = 200000;

  // Expected fields of one translation result
  typedef struct packed {
    logic [PADDR_W-1:0] phys_addr;
    logic [FIDX_W-1:0]  frame_index;
    logic               tlb_hit;
    logic               page_fault;
    logic               evicted;
    cnt_t               hit_total;
    cnt_t               miss_total;
  } translation_t;

  // One row of the directed table; typed rows carry a hand-written result
  typedef struct {
    page_t               pg;
    logic [OFFSET_W-1:0] off;
    bit                  typed;
    translation_t        want;
  } access_row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_tvalid_i;
  logic                  s_tready_o;
  logic [IN_DATA_W-1:0]  s_tdata_i;   // [7:0] virt_page, [15:8] page_offset
  logic                  m_tvalid_o;
  logic                  m_tready_i;
  logic [OUT_DATA_W-1:0] m_tdata_o;   // [11:0] phys_addr, [15:12] frame_index,
                                      // [47:16] hit_total, [79:48] miss_total
  logic [OUT_USER_W-1:0] m_tuser_o;   // [0] tlb_hit, [1] page_fault, [2] evicted

  tlb_page_frame_translator_unit uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tuser_o  (m_tuser_o)
  );

  // Predictor state: TLB, frame tags, load counts and the two totals
  bit     tlb_ok     [TLB_ENTRIES];
  page_t  tlb_vpage  [TLB_ENTRIES];
  frame_t tlb_pframe [TLB_ENTRIES];
  bit     frm_used   [NUM_FRAMES];
  page_t  frm_vpage  [NUM_FRAMES];
  cnt_t   frm_loads  [NUM_FRAMES];
  cnt_t   hit_cnt;
  cnt_t   miss_cnt;

  translation_t translations_due[$];
  access_row_t  access_table[$];

  int unsigned mismatches;
  int unsigned cycles;
  int unsigned sent_requests;
  int unsigned seen_hits;
  int unsigned seen_faults;
  int unsigned seen_evictions;
  bit          src_calm;
  bit          rx_calm;

  // --------------------------------------------------------------------------
  // Clock, cycle limit
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("tb_tlb_page_frame_translator_unit NOT OK");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  function automatic cnt_t bump(input cnt_t v);
    return (v == CNT_MAX) ? v : v + cnt_t'(1);
  endfunction

  // Translate one access and advance the predicted state.
  function automatic translation_t translate_access(input page_t pg,
                                                    input logic [OFFSET_W-1:0] off);
    translation_t r;
    frame_t       fr;
    bit           found;
    int           best;
    slot_t        slot;
    r     = '0;
    fr    = '0;
    found = 1'b0;
    for (int i = 0; i < TLB_ENTRIES; i++) begin
      if (!r.tlb_hit && tlb_ok[i] && tlb_vpage[i] == pg) begin
        fr        = tlb_pframe[i];
        r.tlb_hit = 1'b1;
      end
    end
    if (r.tlb_hit) begin
      hit_cnt = bump(hit_cnt);
    end else begin
      miss_cnt = bump(miss_cnt);
      for (int i = 0; i < NUM_FRAMES; i++) begin
        if (!found && frm_used[i] && frm_vpage[i] == pg) begin
          fr    = frame_t'(i);
          found = 1'b1;
        end
      end
      if (!found) begin
        r.page_fault = 1'b1;
        // lowest free frame first, else lowest index with fewest loads
        best = -1;
        for (int i = 0; i < NUM_FRAMES; i++) begin
          if (best < 0 && !frm_used[i]) best = i;
        end
        if (best < 0) begin
          r.evicted = 1'b1;
          best      = 0;
          for (int i = 1; i < NUM_FRAMES; i++) begin
            if (frm_loads[i] < frm_loads[best]) best = i;
          end
        end
        fr            = frame_t'(best);
        frm_used[fr]  = 1'b1;
        frm_vpage[fr] = pg;
        frm_loads[fr] = bump(frm_loads[fr]);
        // drop stale mappings of the reused frame, then fill the miss slot
        for (int i = 0; i < TLB_ENTRIES; i++) begin
          if (tlb_ok[i] && tlb_pframe[i] == fr) tlb_ok[i] = 1'b0;
        end
        slot             = slot_t'(miss_cnt % TLB_ENTRIES);
        tlb_ok[slot]     = 1'b1;
        tlb_vpage[slot]  = pg;
        tlb_pframe[slot] = fr;
      end
    end
    r.frame_index = FIDX_W'(fr);
    r.phys_addr   = PADDR_W'(int'(fr) * PAGE_BYTES + int'(off) % PAGE_BYTES);
    r.hit_total   = hit_cnt;
    r.miss_total  = miss_cnt;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------
  function automatic void add_row(input page_t pg, input logic [OFFSET_W-1:0] off,
                                  input bit typed, input translation_t want);
    access_row_t row;
    row.pg    = pg;
    row.off   = off;
    row.typed = typed;
    row.want  = want;
    access_table.push_back(row);
  endfunction

  // Entered at a falling edge; returns at the falling edge after acceptance.
  // Valid stays high into the next request when no gap is drawn.
  task automatic send_request(input page_t pg, input logic [OFFSET_W-1:0] off,
                              input bit typed, input translation_t want);
    int unsigned  gap;
    translation_t predicted;
    gap = src_calm ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      s_tvalid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_tvalid_i = 1'b1;
    s_tdata_i  = {off, pg};
    do @(posedge clk_i); while (!s_tready_o);
    predicted = translate_access(pg, off);
    translations_due.push_back(typed ? want : predicted);
    sent_requests++;
    seen_hits      += 32'(predicted.tlb_hit);
    seen_faults    += 32'(predicted.page_fault);
    seen_evictions += 32'(predicted.evicted);
    @(negedge clk_i);
  endtask

  initial begin
    page_t               hot_base;
    int unsigned         hot_span;
    page_t               pg;
    logic [OFFSET_W-1:0] off;

    rst_ni     = 1'b0;
    s_tvalid_i = 1'b0;
    s_tdata_i  = '0;
    m_tready_i = 1'b0;
    mismatches = 0;
    cycles     = 0;
    src_calm   = 1'b0;
    rx_calm    = 1'b0;
    hit_cnt    = '0;
    miss_cnt   = '0;
    for (int i = 0; i < TLB_ENTRIES; i++) tlb_ok[i] = 1'b0;
    for (int i = 0; i < NUM_FRAMES; i++) begin
      frm_used[i]  = 1'b0;
      frm_loads[i] = '0;
    end

    // Directed table: offset extremes, first fault, hits, frame fill,
    // victim on a full load-count tie, re-fault of an evicted page, and the
    // top frame with the top offset.
    add_row(8'h00, 8'h00, 1'b1, '{12'h000, 4'h0, 1'b0, 1'b1, 1'b0, 32'd0, 32'd1});
    add_row(8'h00, 8'hFF, 1'b1, '{12'h0FF, 4'h0, 1'b1, 1'b0, 1'b0, 32'd1, 32'd1});
    add_row(8'hFF, 8'hFF, 1'b1, '{12'h1FF, 4'h1, 1'b0, 1'b1, 1'b0, 32'd1, 32'd2});
    add_row(8'hFF, 8'h00, 1'b1, '{12'h100, 4'h1, 1'b1, 1'b0, 1'b0, 32'd2, 32'd2});
    for (int k = 1; k <= 14; k++) add_row(page_t'(k), 8'(8'h11 * k), 1'b0, '0);
    // all frames hold one load each: the tie goes to frame 0
    add_row(8'h80, 8'hA5, 1'b1, '{12'h0A5, 4'h0, 1'b0, 1'b1, 1'b1, 32'd2, 32'd17});
    add_row(8'h00, 8'h5A, 1'b0, '0);
    add_row(8'hFF, 8'hC3, 1'b0, '0);
    add_row(8'h80, 8'h3C, 1'b0, '0);
    add_row(8'h0E, 8'hFF, 1'b0, '0);
    add_row(8'h01, 8'h00, 1'b0, '0);

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (access_table[i]) begin
      send_request(access_table[i].pg, access_table[i].off,
                   access_table[i].typed, access_table[i].want);
    end

    // Random part: mostly a moving hot window, from narrower to wider than
    // the frame set (hits, faults and evictions), the rest spread over all pages.
    hot_base = page_t'($urandom_range(0, 255));
    hot_span = 20;
    for (int n = 0; n < RANDOM_COUNT; n++) begin
      if (n % 50 == 0) begin
        hot_base = page_t'($urandom_range(0, 255));
        hot_span = $urandom_range(8, 28);
        src_calm = ($urandom_range(0, 3) == 0);
      end
      if ($urandom_range(0, 9) < 7) pg = page_t'(hot_base + $urandom_range(0, hot_span - 1));
      else pg = page_t'($urandom_range(0, 255));
      off = OFFSET_W'($urandom_range(0, 255));
      send_request(pg, off, 1'b0, '0);
    end
    s_tvalid_i = 1'b0;

    // Drain, then watch a little longer for stray results
    wait (translations_due.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d requests: %0d TLB hits, %0d page faults, %0d evictions.",
             sent_requests, seen_hits, seen_faults, seen_evictions);
    $display("Result mismatches or stray results: %0d, still outstanding: %0d.",
             mismatches, translations_due.size());
    if (mismatches == 0 && translations_due.size() == 0) begin
      $display("tb_tlb_page_frame_translator_unit OK");
    end else begin
      $display("tb_tlb_page_frame_translator_unit NOT OK");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Result side: random stall before each result, with calm stretches
  // --------------------------------------------------------------------------
  initial begin
    int unsigned stall;
    int unsigned taken;
    taken = 0;
    wait (rst_ni);
    @(negedge clk_i);
    forever begin
      if (taken % 60 == 0) rx_calm = ($urandom_range(0, 3) == 0);
      stall = rx_calm ? 0 : $urandom_range(0, 16);
      if (stall > 0) begin
        m_tready_i = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_tready_i = 1'b1;
      do @(posedge clk_i); while (!m_tvalid_o);
      taken++;
      @(negedge clk_i);
    end
  end

  // --------------------------------------------------------------------------
  // Checker
  // --------------------------------------------------------------------------
  function automatic void compare_field(input string name, input longint unsigned want,
                                        input longint unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin
    translation_t want;
    if (rst_ni && m_tvalid_o && m_tready_i) begin
      if (translations_due.size() == 0) begin
        $error("result with no request outstanding: tdata 0x%0h tuser 0x%0h",
               m_tdata_o, m_tuser_o);
        mismatches++;
      end else begin
        want = translations_due.pop_front();
        compare_field("phys_addr",   64'(want.phys_addr),   64'(m_tdata_o[11:0]));
        compare_field("frame_index", 64'(want.frame_index), 64'(m_tdata_o[15:12]));
        compare_field("hit_total",   64'(want.hit_total),   64'(m_tdata_o[47:16]));
        compare_field("miss_total",  64'(want.miss_total),  64'(m_tdata_o[79:48]));
        compare_field("tlb_hit",     64'(want.tlb_hit),     64'(m_tuser_o[0]));
        compare_field("page_fault",  64'(want.page_fault),  64'(m_tuser_o[1]));
        compare_field("evicted",     64'(want.evicted),     64'(m_tuser_o[2]));
      end
    end
  end

endmodule
